@@ sv/dmtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtt_pkg: shared types and constants of the transposition table
// Field widths, request codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package dmtt_pkg;

    localparam int KEY_BITS      = 64;
    localparam int TYPE_BITS     = 2;
    localparam int DEPTH_BITS    = 6;
    localparam int TURN_BITS     = 7;
    localparam int PAY_PORT_BITS = 32;
    localparam int PAY_MAX_BITS  = 40;

    localparam int INDEX_BITS_DEF   = 10;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic                 CMD_LOOKUP = 1'b0;
    localparam logic                 CMD_STORE  = 1'b1;
    localparam logic [TYPE_BITS-1:0] TYPE_EMPTY = '0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

@@ sv/dmtt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtt_ctrl: request sequencer
// Runs the clearing sweep after reset, then takes one request at a time
// through a registered slot read and then an update.
// ----------------------------------------------------------------------------
module dmtt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output dmtt_pkg::dp_cmd_t    cmd,
    input  dmtt_pkg::dp_status_t status
);
    import dmtt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ sv/dmtt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtt_datapath: slot memory, request registers and replacement logic
// Holds key and entry of every slot in one memory, compares the stored key,
// decides replacement and registers the result.
// ----------------------------------------------------------------------------
module dmtt_datapath #(
    parameter int INDEX_BITS   = dmtt_pkg::INDEX_BITS_DEF,
    parameter int PAYLOAD_BITS = dmtt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmtt_pkg::dp_cmd_t                    cmd,
    output dmtt_pkg::dp_status_t                 status,
    input  logic                                 command,
    input  logic [dmtt_pkg::KEY_BITS-1:0]        key,
    input  logic [dmtt_pkg::TYPE_BITS-1:0]       entry_type,
    input  logic [dmtt_pkg::DEPTH_BITS-1:0]      search_depth,
    input  logic [dmtt_pkg::TURN_BITS-1:0]       turn_number,
    input  logic [dmtt_pkg::PAY_PORT_BITS-1:0]   payload,
    output logic                                 done,
    output logic                                 hit,
    output logic [dmtt_pkg::TYPE_BITS-1:0]       found_type,
    output logic [dmtt_pkg::DEPTH_BITS-1:0]      found_depth,
    output logic [dmtt_pkg::TURN_BITS-1:0]       found_turn,
    output logic [dmtt_pkg::PAY_PORT_BITS-1:0]   found_payload,
    output logic                                 written
);
    import dmtt_pkg::*;

    localparam int SLOTS   = 1 << INDEX_BITS;
    localparam int SLOT_W  = KEY_BITS + TYPE_BITS + DEPTH_BITS + TURN_BITS + PAYLOAD_BITS;
    localparam int SUM_W   = DEPTH_BITS + 2;

    logic [SLOT_W-1:0] mem [SLOTS];

    logic [INDEX_BITS-1:0]   clr_cnt_reg;
    logic [INDEX_BITS-1:0]   clr_cnt_next;
    logic                    cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [TYPE_BITS-1:0]    type_reg;
    logic [DEPTH_BITS-1:0]   depth_reg;
    logic [TURN_BITS-1:0]    turn_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [SLOT_W-1:0]       rd_reg;

    logic                    done_reg;
    logic                    hit_reg;
    logic [TYPE_BITS-1:0]    ftype_reg;
    logic [DEPTH_BITS-1:0]   fdepth_reg;
    logic [TURN_BITS-1:0]    fturn_reg;
    logic [PAY_PORT_BITS-1:0] fpay_reg;
    logic                    written_reg;

    logic [PAY_MAX_BITS-1:0] pay_in_ext;
    logic [PAY_MAX_BITS-1:0] pay_old_ext;
    logic [KEY_BITS-1:0]     old_key;
    logic [TYPE_BITS-1:0]    old_type;
    logic [DEPTH_BITS-1:0]   old_depth;
    logic [TURN_BITS-1:0]    old_turn;
    logic [PAYLOAD_BITS-1:0] old_pay;
    logic [SUM_W-1:0]        age_sum;
    logic                    key_match;
    logic                    replace;
    logic                    upd_wr;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   wr_idx;
    logic [SLOT_W-1:0]       wr_data;

    assign status.clear_last = &clr_cnt_reg;
    assign clr_cnt_next      = clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign pay_in_ext = {{(PAY_MAX_BITS - PAY_PORT_BITS){1'b0}}, payload};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            type_reg  <= entry_type;
            depth_reg <= search_depth;
            turn_reg  <= turn_number;
            pay_reg   <= pay_in_ext[PAYLOAD_BITS-1:0];
            rd_reg    <= mem[key[KEY_BITS-1 -: INDEX_BITS]];
        end
    end

    assign {old_key, old_type, old_depth, old_turn, old_pay} = rd_reg;
    assign pay_old_ext = {{(PAY_MAX_BITS - PAYLOAD_BITS){1'b0}}, old_pay};

    assign key_match = (old_key == key_reg);
    assign age_sum   = {1'b0, old_turn} + {2'b00, old_depth};
    assign replace   = (old_type == TYPE_EMPTY) || (depth_reg >= old_depth)
                       || ({1'b0, turn_reg} > age_sum);
    assign upd_wr    = cmd.exec && (cmd_reg == CMD_STORE) && replace;

    always_comb
    begin
        mem_we  = 1'b0;
        wr_idx  = key_reg[KEY_BITS-1 -: INDEX_BITS];
        wr_data = {key_reg, type_reg, depth_reg, turn_reg, pay_reg};
        if (cmd.clear_wr)
        begin
            mem_we  = 1'b1;
            wr_idx  = clr_cnt_reg;
            wr_data = '0;
        end
        else if (upd_wr)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            hit_reg     <= 1'b0;
            ftype_reg   <= '0;
            fdepth_reg  <= '0;
            fturn_reg   <= '0;
            fpay_reg    <= '0;
            written_reg <= upd_wr;
            if (cmd_reg == CMD_LOOKUP && key_match)
            begin
                hit_reg    <= 1'b1;
                ftype_reg  <= old_type;
                fdepth_reg <= old_depth;
                fturn_reg  <= old_turn;
                fpay_reg   <= pay_old_ext[PAY_PORT_BITS-1:0];
            end
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign found_type    = ftype_reg;
    assign found_depth   = fdepth_reg;
    assign found_turn    = fturn_reg;
    assign found_payload = fpay_reg;
    assign written       = written_reg;

endmodule

@@ sv/direct_mapped_transposition_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_top: direct-mapped transposition table
// Lookup by full key match; a store replaces an empty slot, an entry of no
//   greater depth, or one whose turn plus depth lies below the new turn.
// Each request takes a registered read of the slot memory, then the update;
//   done strobes the result registered in the update; busy blocks new requests.
// Reset: a clearing sweep over all 2^INDEX_BITS slots empties every slot; busy
//   stays high until it ends. The receiver takes every result at once.
// ----------------------------------------------------------------------------
module direct_mapped_transposition_table_top #(
    parameter int INDEX_BITS   = dmtt_pkg::INDEX_BITS_DEF,
    parameter int PAYLOAD_BITS = dmtt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic [dmtt_pkg::KEY_BITS-1:0]        key,
    input  logic [dmtt_pkg::TYPE_BITS-1:0]       entry_type,
    input  logic [dmtt_pkg::DEPTH_BITS-1:0]      search_depth,
    input  logic [dmtt_pkg::TURN_BITS-1:0]       turn_number,
    input  logic [dmtt_pkg::PAY_PORT_BITS-1:0]   payload,
    output logic                                 done,
    output logic                                 hit,
    output logic [dmtt_pkg::TYPE_BITS-1:0]       found_type,
    output logic [dmtt_pkg::DEPTH_BITS-1:0]      found_depth,
    output logic [dmtt_pkg::TURN_BITS-1:0]       found_turn,
    output logic [dmtt_pkg::PAY_PORT_BITS-1:0]   found_payload,
    output logic                                 written
);
    import dmtt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dmtt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    dmtt_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .key           (key),
        .entry_type    (entry_type),
        .search_depth  (search_depth),
        .turn_number   (turn_number),
        .payload       (payload),
        .done          (done),
        .hit           (hit),
        .found_type    (found_type),
        .found_depth   (found_depth),
        .found_turn    (found_turn),
        .found_payload (found_payload),
        .written       (written)
    );

endmodule

@@ tb/sv/direct_mapped_transposition_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_checker: result checker for the table
// Watches accepted requests and result strobes, keeps its own copy of the
// slot keys and entries, works out each lookup or store outcome and compares
// every strobed result with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module direct_mapped_transposition_table_checker #(
    parameter int INDEX_BITS   = dmtt_pkg::INDEX_BITS_DEF,
    parameter int PAYLOAD_BITS = dmtt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 command,
    input  logic [dmtt_pkg::KEY_BITS-1:0]        key,
    input  logic [dmtt_pkg::TYPE_BITS-1:0]       entry_type,
    input  logic [dmtt_pkg::DEPTH_BITS-1:0]      search_depth,
    input  logic [dmtt_pkg::TURN_BITS-1:0]       turn_number,
    input  logic [dmtt_pkg::PAY_PORT_BITS-1:0]   payload,
    input  logic                                 done,
    input  logic                                 hit,
    input  logic [dmtt_pkg::TYPE_BITS-1:0]       found_type,
    input  logic [dmtt_pkg::DEPTH_BITS-1:0]      found_depth,
    input  logic [dmtt_pkg::TURN_BITS-1:0]       found_turn,
    input  logic [dmtt_pkg::PAY_PORT_BITS-1:0]   found_payload,
    input  logic                                 written,
    output int                                   fail_count,
    output int                                   outstanding,
    output int                                   lookup_count,
    output int                                   store_count,
    output int                                   hit_count,
    output int                                   write_count
);
    import dmtt_pkg::*;

    localparam int          SLOTS    = 1 << INDEX_BITS;
    localparam logic [63:0] PAY_KEEP = (64'd1 << PAYLOAD_BITS) - 64'd1;

    typedef struct packed {
        logic                     hit;
        logic [TYPE_BITS-1:0]     etype;
        logic [DEPTH_BITS-1:0]    depth;
        logic [TURN_BITS-1:0]     turn;
        logic [PAY_PORT_BITS-1:0] pay;
        logic                     written;
    } outcome_t;

    logic [KEY_BITS-1:0]      slot_key   [SLOTS];
    logic [TYPE_BITS-1:0]     slot_type  [SLOTS];
    logic [DEPTH_BITS-1:0]    slot_depth [SLOTS];
    logic [TURN_BITS-1:0]     slot_turn  [SLOTS];
    logic [PAY_PORT_BITS-1:0] slot_pay   [SLOTS];

    outcome_t table_outcomes[$];
    outcome_t fresh;
    outcome_t oldest;

    int mismatches = 0;
    int waiting    = 0;
    int lookups    = 0;
    int stores     = 0;
    int hits       = 0;
    int writes     = 0;

    assign fail_count   = mismatches;
    assign outstanding  = waiting;
    assign lookup_count = lookups;
    assign store_count  = stores;
    assign hit_count    = hits;
    assign write_count  = writes;

    task automatic resolve_request(output outcome_t res);
        int unsigned        slot;
        logic [TURN_BITS:0] horizon;
        logic               replace;
        slot    = int'(key[KEY_BITS-1 -: INDEX_BITS]);
        horizon = {1'b0, slot_turn[slot]} + slot_depth[slot];
        res     = '0;
        if (command == CMD_LOOKUP)
        begin
            if (slot_key[slot] == key)
            begin
                res.hit   = 1'b1;
                res.etype = slot_type[slot];
                res.depth = slot_depth[slot];
                res.turn  = slot_turn[slot];
                res.pay   = slot_pay[slot];
            end
        end
        else
        begin
            replace = (slot_type[slot] == TYPE_EMPTY) || (search_depth >= slot_depth[slot])
                      || ({1'b0, turn_number} > horizon);
            if (replace)
            begin
                slot_key[slot]   = key;
                slot_type[slot]  = entry_type;
                slot_depth[slot] = search_depth;
                slot_turn[slot]  = turn_number;
                slot_pay[slot]   = payload & PAY_KEEP[PAY_PORT_BITS-1:0];
                res.written      = 1'b1;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key[i]   = '0;
                slot_type[i]  = TYPE_EMPTY;
                slot_depth[i] = '0;
                slot_turn[i]  = '0;
                slot_pay[i]   = '0;
            end
            table_outcomes.delete();
            waiting = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (table_outcomes.size() == 0)
                begin
                    $display("%0t: stray result strobe, expected none, actual hit %0b written %0b",
                             $time, hit, written);
                    mismatches++;
                end
                else
                begin
                    oldest = table_outcomes.pop_front();
                    compare_field("hit", oldest.hit, hit);
                    compare_field("found_type", oldest.etype, found_type);
                    compare_field("found_depth", oldest.depth, found_depth);
                    compare_field("found_turn", oldest.turn, found_turn);
                    compare_field("found_payload", oldest.pay, found_payload);
                    compare_field("written", oldest.written, written);
                end
            end
            if (start && !busy)
            begin
                resolve_request(fresh);
                table_outcomes.push_back(fresh);
                if (command == CMD_LOOKUP)
                begin
                    lookups++;
                    hits += fresh.hit;
                end
                else
                begin
                    stores++;
                    writes += fresh.written;
                end
            end
            waiting = table_outcomes.size();
        end
    end

endmodule

@@ tb/sv/direct_mapped_transposition_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_top_test: testbench of the table
// Drives directed lookups and stores around empty slots, key collisions and
// each replacement rule, then bursts of random requests aimed at a small set
// of shared slots; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module direct_mapped_transposition_table_top_test;
    import dmtt_pkg::*;

    localparam int INDEX_BITS      = INDEX_BITS_DEF;
    localparam int SLOTS           = 1 << INDEX_BITS;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 500;
    localparam int POOL_SIZE       = 16;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     start        = 1'b0;
    logic                     command      = CMD_LOOKUP;
    logic [KEY_BITS-1:0]      key          = '0;
    logic [TYPE_BITS-1:0]     entry_type   = TYPE_EMPTY;
    logic [DEPTH_BITS-1:0]    search_depth = '0;
    logic [TURN_BITS-1:0]     turn_number  = '0;
    logic [PAY_PORT_BITS-1:0] payload      = '0;

    logic                     busy;
    logic                     done;
    logic                     hit;
    logic [TYPE_BITS-1:0]     found_type;
    logic [DEPTH_BITS-1:0]    found_depth;
    logic [TURN_BITS-1:0]     found_turn;
    logic [PAY_PORT_BITS-1:0] found_payload;
    logic                     written;

    int fail_count;
    int outstanding;
    int lookup_count;
    int store_count;
    int hit_count;
    int write_count;
    int cycle_count;

    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int unsigned         pool_slot [4];

    direct_mapped_transposition_table_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .key           (key),
        .entry_type    (entry_type),
        .search_depth  (search_depth),
        .turn_number   (turn_number),
        .payload       (payload),
        .done          (done),
        .hit           (hit),
        .found_type    (found_type),
        .found_depth   (found_depth),
        .found_turn    (found_turn),
        .found_payload (found_payload),
        .written       (written)
    );

    direct_mapped_transposition_table_checker table_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .key           (key),
        .entry_type    (entry_type),
        .search_depth  (search_depth),
        .turn_number   (turn_number),
        .payload       (payload),
        .done          (done),
        .hit           (hit),
        .found_type    (found_type),
        .found_depth   (found_depth),
        .found_turn    (found_turn),
        .found_payload (found_payload),
        .written       (written),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .lookup_count  (lookup_count),
        .store_count   (store_count),
        .hit_count     (hit_count),
        .write_count   (write_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [KEY_BITS-1:0] key_in_slot(input int unsigned slot,
                                                        input logic [KEY_BITS-1:0] tail);
        logic [KEY_BITS-1:0] k;
        k = tail;
        k[KEY_BITS-1 -: INDEX_BITS] = slot[INDEX_BITS-1:0];
        return k;
    endfunction

    task automatic issue_request(input logic cmd, input logic [KEY_BITS-1:0] k,
                                 input logic [TYPE_BITS-1:0] et,
                                 input logic [DEPTH_BITS-1:0] d,
                                 input logic [TURN_BITS-1:0] t,
                                 input logic [PAY_PORT_BITS-1:0] p);
        @(negedge clk);
        start        = 1'b1;
        command      = cmd;
        key          = k;
        entry_type   = et;
        search_depth = d;
        turn_number  = t;
        payload      = p;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic hold_idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start        = 1'b0;
            command      = 1'($urandom_range(0, 1));
            key          = {$urandom, $urandom};
            entry_type   = 2'($urandom_range(0, 3));
            search_depth = 6'($urandom_range(0, 63));
            turn_number  = 7'($urandom_range(0, 127));
            payload      = $urandom;
        end
    endtask

    initial
    begin
        int                  sent;
        int                  burst;
        int                  gap;
        int                  pick;
        logic                rcmd;
        logic [KEY_BITS-1:0] rkey;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // empty table, key zero, all-ones key and the turn horizon at its top
        issue_request(CMD_LOOKUP, '0, 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_LOOKUP, '1, 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_STORE, '1, 2'd3, 6'd63, 7'd127, 32'hFFFF_FFFF);
        issue_request(CMD_LOOKUP, '1, 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_STORE, key_in_slot(SLOTS - 1, '0), 2'd1, 6'd62, 7'd127, 32'h1);
        issue_request(CMD_LOOKUP, key_in_slot(SLOTS - 1, '0), 2'd0, 6'd0, 7'd0, 32'h0);

        // equal depth, turn at and past the horizon
        issue_request(CMD_STORE, key_in_slot(5, 64'h11), 2'd1, 6'd10, 7'd20, 32'h0);
        issue_request(CMD_STORE, key_in_slot(5, 64'h22), 2'd2, 6'd10, 7'd20, 32'hA5A5_A5A5);
        issue_request(CMD_STORE, key_in_slot(5, 64'h33), 2'd3, 6'd9, 7'd30, 32'h3);
        issue_request(CMD_STORE, key_in_slot(5, 64'h33), 2'd3, 6'd9, 7'd31, 32'h4);
        issue_request(CMD_LOOKUP, key_in_slot(5, 64'h22), 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_LOOKUP, key_in_slot(5, 64'h33), 2'd0, 6'd0, 7'd0, 32'h0);

        // empty-type entry still hits, then yields to any store
        issue_request(CMD_STORE, key_in_slot(6, 64'h44), TYPE_EMPTY, 6'd5, 7'd3, 32'h1234_5678);
        issue_request(CMD_LOOKUP, key_in_slot(6, 64'h44), 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_STORE, key_in_slot(6, 64'h55), 2'd1, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_LOOKUP, key_in_slot(6, 64'h44), 2'd0, 6'd0, 7'd0, 32'h0);

        // slot zero and the zero key
        issue_request(CMD_STORE, '0, 2'd2, 6'd0, 7'd0, 32'h5A5A_5A5A);
        issue_request(CMD_LOOKUP, key_in_slot(0, 64'h1), 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_LOOKUP, '0, 2'd0, 6'd0, 7'd0, 32'h0);
        issue_request(CMD_STORE, key_in_slot(7, 64'h1), 2'd1, 6'd0, 7'd127, 32'h8000_0001);
        issue_request(CMD_STORE, key_in_slot(7, 64'h2), 2'd2, 6'd0, 7'd0, 32'h7FFF_FFFE);
        hold_idle(3);

        pool_slot[0] = 0;
        pool_slot[1] = SLOTS - 1;
        pool_slot[2] = $urandom_range(1, SLOTS - 2);
        pool_slot[3] = $urandom_range(1, SLOTS - 2);
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = key_in_slot(pool_slot[i % 4], {$urandom, $urandom});

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                pick = $urandom_range(0, 9);
                rcmd = 1'($urandom_range(0, 1));
                if (pick <= 6)
                    rkey = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (pick == 7)
                    rkey = key_in_slot(pool_slot[$urandom_range(0, 3)], {$urandom, $urandom});
                else if (pick == 8)
                    rkey = {$urandom, $urandom};
                else
                    rkey = $urandom_range(0, 1) ? '1 : '0;
                issue_request(rcmd, rkey, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                              7'($urandom_range(0, 127)), $urandom);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                hold_idle(gap);
        end
        hold_idle(1);

        while (outstanding != 0)
            @(negedge clk);
        hold_idle(6);

        $display("Covered %0d lookups with %0d hits and %0d stores with %0d slot writes,",
                 lookup_count, hit_count, store_count, write_count);
        $display("over shared slots, key collisions, empty-type entries and the zero key.");
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ direct_mapped_transposition_table_top.f @@
sv/dmtt_pkg.sv
sv/dmtt_ctrl.sv
sv/dmtt_datapath.sv
sv/direct_mapped_transposition_table_top.sv
tb/sv/direct_mapped_transposition_table_checker.sv
tb/sv/direct_mapped_transposition_table_top_test.sv
